// ----- rtl/core/pmq_pkg.sv -----
// pmq_pkg: shared types, constants and helpers of the priority message queue
// depends on nothing; used by pmq_cell and priority_message_queue
`default_nettype none

package pmq_pkg;

	// store geometry
	localparam int DEPTH         = 16;
	localparam int PAYLOAD_BYTES = 8;
	localparam int OCC_W         = $clog2(DEPTH + 1);

	// fixed field widths
	localparam int DATA_W = 64;
	localparam int LEN_W  = 4;
	localparam int PRIO_W = 8;
	localparam int CAP_W  = 5;
	localparam int REG_W  = 4;
	localparam int CFG_W  = 8;

	// configuration register indexes
	localparam logic [REG_W-1:0] REG_CAPACITY_LIMIT = REG_W'(0);
	localparam logic [REG_W-1:0] REG_SIZE_LIMIT     = REG_W'(1);

	// register reset values
	localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);
	localparam logic [LEN_W-1:0] SIZE_RESET     = LEN_W'(8);

	typedef enum logic {
		OP_SEND    = 1'b0,
		OP_RECEIVE = 1'b1
	} op_t;

	typedef enum logic {
		ST_OK    = 1'b0,
		ST_ERROR = 1'b1
	} status_t;

	typedef struct packed {
		op_t               operation;
		logic [DATA_W-1:0] payload;
		logic [LEN_W-1:0]  length;
		logic [PRIO_W-1:0] priority_req;
		logic [LEN_W-1:0]  receive_limit;
	} in_item_t;

	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] read_data;
		logic [LEN_W-1:0]  read_length;
		logic [PRIO_W-1:0] read_priority;
	} out_item_t;

	// one stored message
	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [LEN_W-1:0]  length;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	// command broadcast to every cell
	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t new_entry;
	} cell_cmd_t;

	// mask of the low n bytes of a data word
	function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
		logic [DATA_W-1:0] m;
		m = '0;
		for (int b = 0; b < DATA_W / 8; b++) begin
			if (LEN_W'(b) < n) begin
				m[8*b +: 8] = 8'hff;
			end
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pmq_cell.sv -----
// pmq_cell: one slot of the sorted message chain
// depends on pmq_pkg; a row of these is built by priority_message_queue
`default_nettype none

module pmq_cell (
	input  wire                      clk,
	input  wire pmq_pkg::cell_cmd_t  cmd,
	input  wire                      in_use,
	input  wire                      prev_keep,
	input  wire pmq_pkg::entry_t     prev_entry,
	input  wire pmq_pkg::entry_t     next_entry,
	output pmq_pkg::entry_t          entry,
	output logic                     keep
);
	import pmq_pkg::*;

	entry_t entry_q;

	// slot stays put on insert when it holds an equal or more urgent message
	assign keep  = in_use && (entry_q.prio <= cmd.new_entry.prio);
	assign entry = entry_q;

	// insert shifts toward the tail, pop shifts toward the head
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (!keep) begin
				entry_q <= prev_keep ? cmd.new_entry : prev_entry;
			end
		end else if (cmd.pop) begin
			entry_q <= next_entry;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/priority_message_queue.sv -----
// priority_message_queue: top level of the sorted message queue
// depends on pmq_pkg and pmq_cell
`default_nettype none

// Usage
//   Command channel: drive cmd and raise start; the command transfers at a
//   rising edge where start is high and busy is low. busy stays low, so a
//   command may be issued every cycle.
//   A send inserts the message behind all entries of equal or smaller
//   priority value; a receive pops the head, cut to receive_limit.
//   Result channel: in the cycle after each transfer, done is high for one
//   cycle with result valid. The receiver cannot stall; the result must be
//   taken in that cycle.
//   Throughput is one command per cycle: every slot of the cell chain
//   compares its priority against the new one and shifts in the same cycle.
//   Configuration: cfg_valid with cfg_index and cfg_data; cfg_ready is
//   always high. Index 0 sets capacity_limit, index 1 size_limit, others
//   are ignored. Write only while no command is in flight.
//   Reset: the queue is empty, capacity_limit is 16 and size_limit is 8.
//   No clearing pass is needed; the first command may follow reset at once.

module priority_message_queue (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	output logic                      busy,
	input  wire pmq_pkg::in_item_t    cmd,
	output logic                      done,
	output pmq_pkg::out_item_t        result,
	input  wire                       cfg_valid,
	output logic                      cfg_ready,
	input  wire [pmq_pkg::REG_W-1:0]  cfg_index,
	input  wire [pmq_pkg::CFG_W-1:0]  cfg_data
);
	import pmq_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	logic [LEN_W-1:0] size_q;
	logic [OCC_W-1:0] occupancy_q;
	logic             done_q;
	out_item_t        result_q;

	entry_t           cell_entry [DEPTH];
	logic [DEPTH-1:0] cell_keep;
	logic [DEPTH-1:0] cell_in_use;

	cell_cmd_t        cell_cmd;
	logic             accept;
	logic             len_bad;
	logic             full;
	logic             push_ok;
	logic             pop_ok;
	logic [LEN_W-1:0] rd_len;
	out_item_t        result_d;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
			size_q     <= SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CAPACITY_LIMIT: capacity_q <= cfg_data[CAP_W-1:0];
				REG_SIZE_LIMIT:     size_q     <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// send and receive admission
	always_comb begin
		len_bad = (cmd.length == '0) || (cmd.length > size_q)
			|| (32'(cmd.length) > PAYLOAD_BYTES);
		full    = ({{(32-OCC_W){1'b0}}, occupancy_q} >= {{(32-CAP_W){1'b0}}, capacity_q})
			|| (32'(occupancy_q) >= DEPTH);
		push_ok = accept && (cmd.operation == OP_SEND) && !len_bad && !full;
		pop_ok  = accept && (cmd.operation == OP_RECEIVE) && (occupancy_q != '0);
	end

	// command to the cell chain
	always_comb begin
		cell_cmd.push           = push_ok;
		cell_cmd.pop            = pop_ok;
		cell_cmd.new_entry.data = cmd.payload & byte_mask(cmd.length);
		cell_cmd.new_entry.length = cmd.length;
		cell_cmd.new_entry.prio = cmd.priority_req;
	end

	// row of cells, head at slot zero
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		logic   prev_k;

		assign cell_in_use[i] = OCC_W'(i) < occupancy_q;

		if (i == 0) begin : g_head
			assign prev_e = '0;
			assign prev_k = 1'b1;
		end else begin : g_body
			assign prev_e = cell_entry[i-1];
			assign prev_k = cell_keep[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_e = '0;
		end else begin : g_mid
			assign next_e = cell_entry[i+1];
		end

		pmq_cell u_cell (
			.clk        (clk),
			.cmd        (cell_cmd),
			.in_use     (cell_in_use[i]),
			.prev_keep  (prev_k),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.entry      (cell_entry[i]),
			.keep       (cell_keep[i])
		);
	end

	// occupancy count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupancy_q <= '0;
		end else if (push_ok) begin
			occupancy_q <= occupancy_q + OCC_W'(1);
		end else if (pop_ok) begin
			occupancy_q <= occupancy_q - OCC_W'(1);
		end
	end

	// result of the transfer
	always_comb begin
		rd_len = (cmd.receive_limit < cell_entry[0].length)
			? cmd.receive_limit : cell_entry[0].length;
		result_d = '0;
		result_d.status = ST_ERROR;
		if (push_ok) begin
			result_d.status = ST_OK;
		end else if (pop_ok) begin
			result_d.status        = ST_OK;
			result_d.read_data     = cell_entry[0].data & byte_mask(rd_len);
			result_d.read_length   = rd_len;
			result_d.read_priority = cell_entry[0].prio;
		end
	end

	// result register and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// every transfer gives a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("no result after command transfer");

	// occupancy stays within the store
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(occupancy_q) <= DEPTH)
		else $error("occupancy beyond depth");

	// a successful send grows the queue by one
	a_send_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok |=> occupancy_q == $past(occupancy_q) + OCC_W'(1))
		else $error("send did not grow queue");

	// a receive on an empty queue reports an error
	a_empty_error: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.operation == OP_RECEIVE && occupancy_q == '0)
		|=> (result.status == ST_ERROR && result.read_length == '0))
		else $error("empty receive not flagged");

	// returned length never exceeds a payload
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> 32'(result.read_length) <= PAYLOAD_BYTES)
		else $error("read length too large");

endmodule

`default_nettype wire

// ----- tb/pmq_checker.sv -----
// pmq_checker: watches the command, result and register channels of the queue,
// keeps its own sorted copy of the store and compares every result in order
// depends on pmq_pkg for the command and result types

module pmq_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  pmq_pkg::in_item_t         cmd,
	input  logic                      done,
	input  pmq_pkg::out_item_t        result,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [pmq_pkg::REG_W-1:0] cfg_index,
	input  logic [pmq_pkg::CFG_W-1:0] cfg_data,
	output int                        mismatches,
	output int                        outstanding
);

	import pmq_pkg::*;

	// one stored message as the predictor sees it
	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  len;
		logic [7:0]  prio;
	} message_t;

	message_t        sorted_store [DEPTH];
	int              fill_level;
	logic [4:0]      capacity_cfg;
	logic [3:0]      size_cfg;
	out_item_t       pending_replies [$];
	out_item_t       want;
	int              err_count;

	// bytes below n kept, the rest cleared
	function automatic logic [63:0] keep_low_bytes(input logic [63:0] v, input int n);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (b < n) begin
				m[8*b +: 8] = 8'hff;
			end
		end
		return v & m;
	endfunction

	// empty queue, register reset values
	task automatic clear_queue_model();
		for (int i = 0; i < DEPTH; i++) begin
			sorted_store[i] = '0;
		end
		fill_level   = 0;
		capacity_cfg = CAPACITY_RESET;
		size_cfg     = SIZE_RESET;
	endtask

	// apply one command to the model store and return its reply
	function automatic out_item_t apply_command(input in_item_t c);
		out_item_t r;
		int        pos;
		int        n;
		r        = '0;
		r.status = ST_ERROR;
		if (c.operation == OP_SEND) begin
			if (c.length == 0 || c.length > size_cfg || c.length > PAYLOAD_BYTES) begin
				return r;
			end
			if (fill_level >= capacity_cfg || fill_level >= DEPTH) begin
				return r;
			end
			// new message goes behind every entry of equal or smaller priority value
			pos = 0;
			while (pos < fill_level && sorted_store[pos].prio <= c.priority_req) begin
				pos++;
			end
			for (int i = fill_level; i > pos; i--) begin
				sorted_store[i] = sorted_store[i-1];
			end
			sorted_store[pos].data = keep_low_bytes(c.payload, c.length);
			sorted_store[pos].len  = c.length;
			sorted_store[pos].prio = c.priority_req;
			fill_level++;
			r.status = ST_OK;
		end else begin
			if (fill_level == 0) begin
				return r;
			end
			// pop the head, cut to the receiver's limit
			n = sorted_store[0].len;
			if (c.receive_limit < n) begin
				n = c.receive_limit;
			end
			r.status        = ST_OK;
			r.read_data     = keep_low_bytes(sorted_store[0].data, n);
			r.read_length   = 4'(n);
			r.read_priority = sorted_store[0].prio;
			for (int i = 0; i + 1 < fill_level; i++) begin
				sorted_store[i] = sorted_store[i+1];
			end
			fill_level--;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
			err_count++;
		end
	endtask

	// result compare, register tracking and prediction on each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_queue_model();
			pending_replies.delete();
			err_count   = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (done) begin
				if (pending_replies.size() == 0) begin
					$display("%0t: result with nothing expected, actual %h", $time, result);
					err_count++;
				end else begin
					want = pending_replies.pop_front();
					check_field("status", 64'(want.status), 64'(result.status));
					check_field("read_data", want.read_data, result.read_data);
					check_field("read_length", 64'(want.read_length), 64'(result.read_length));
					check_field("read_priority", 64'(want.read_priority),
						64'(result.read_priority));
				end
			end
			// register transfer, unknown indexes ignored
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_CAPACITY_LIMIT) begin
					capacity_cfg = cfg_data[4:0];
				end else if (cfg_index == REG_SIZE_LIMIT) begin
					size_cfg = cfg_data[3:0];
				end
			end
			// command transfer
			if (start && !busy) begin
				pending_replies.push_back(apply_command(cmd));
			end
			mismatches  <= err_count;
			outstanding <= pending_replies.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
// tb: drives commands and register writes into priority_message_queue through
// directed and randomized phases; pmq_checker does the prediction and compare
// depends on pmq_pkg, priority_message_queue and pmq_checker

module tb;

	import pmq_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	in_item_t             cmd;
	logic                 done;
	out_item_t            result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REG_W-1:0]     cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   mismatches;
	int                   outstanding;
	int                   cur_size;

	priority_message_queue uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pmq_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.done        (done),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [63:0] random_word();
		return {$urandom, $urandom};
	endfunction

	function automatic in_item_t send_item(input logic [63:0] data, input int len,
			input int prio);
		in_item_t c;
		c.operation     = OP_SEND;
		c.payload       = data;
		c.length        = 4'(len);
		c.priority_req  = 8'(prio);
		c.receive_limit = 4'($urandom_range(0, 15));
		return c;
	endfunction

	function automatic in_item_t receive_item(input int limit);
		in_item_t c;
		c.operation     = OP_RECEIVE;
		c.payload       = random_word();
		c.length        = 4'($urandom_range(0, 15));
		c.priority_req  = 8'($urandom_range(0, 255));
		c.receive_limit = 4'(limit);
		return c;
	endfunction

	// mostly well-formed sends and receives, biased to fill or drain the queue
	function automatic in_item_t random_item(input bit filling);
		int well_max;
		int len;
		int prio;
		int limit;
		well_max = (cur_size > PAYLOAD_BYTES) ? PAYLOAD_BYTES : cur_size;
		if (well_max < 1) begin
			well_max = 1;
		end
		if ($urandom_range(99) < (filling ? 75 : 25)) begin
			len = ($urandom_range(99) < 85) ? $urandom_range(1, well_max) : $urandom_range(0, 15);
			case ($urandom_range(9))
				0: prio = 0;
				1: prio = 255;
				2, 3, 4, 5: prio = $urandom_range(0, 255);
				default: prio = $urandom_range(0, 7);
			endcase
			return send_item(random_word(), len, prio);
		end
		limit = ($urandom_range(99) < 80) ? $urandom_range(0, 8) : $urandom_range(0, 15);
		return receive_item(limit);
	endfunction

	// present a command and hold it until it transfers
	task automatic issue_command(input in_item_t c);
		cmd   <= c;
		start <= 1'b1;
		do @(negedge clk); while (busy !== 1'b0);
		@(posedge clk);
	endtask

	// stop sending and wait until every reply is back
	task automatic drain_queue();
		start <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_register(input logic [REG_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (cfg_ready !== 1'b1);
		@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// both limits plus a write to an unused index, upper data bits random
	task automatic set_limits(input int cap, input int size);
		write_register(REG_CAPACITY_LIMIT, {3'($urandom_range(0, 7)), 5'(cap)});
		write_register(REG_SIZE_LIMIT, {4'($urandom_range(0, 15)), 4'(size)});
		write_register(REG_W'($urandom_range(2, 15)), 8'($urandom_range(0, 255)));
		cur_size = size;
	endtask

	// stimulus and verdict
	initial begin
		int  caps  [9];
		int  sizes [9];
		int  idles [9];
		bit  filling;
		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		cur_size  = SIZE_RESET;
		caps  = '{16, 4, 1, 31, 16, 0, 10, 16, 16};
		sizes = '{8, 8, 3, 15, 1, 8, 6, 0, 8};
		idles = '{0, 57, 38, 0, 57, 38, 0, 57, 38};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty receive, refused lengths, sorted and equal-priority inserts
		issue_command(receive_item(8));
		issue_command(send_item(random_word(), 0, 5));
		issue_command(send_item(random_word(), 9, 5));
		issue_command(send_item('1, 15, 5));
		issue_command(send_item('1, 8, 255));
		issue_command(send_item('1, 1, 0));
		issue_command(send_item(64'h1122334455667788, 3, 7));
		issue_command(send_item(64'h99aabbccddeeff00, 5, 7));
		issue_command(send_item(random_word(), 2, 128));
		issue_command(receive_item(0));
		issue_command(receive_item(15));
		issue_command(receive_item(2));
		issue_command(receive_item(8));
		issue_command(receive_item(4));
		issue_command(receive_item(8));

		// full queue at a small capacity, then every send refused
		drain_queue();
		set_limits(3, 4);
		issue_command(send_item('1, 4, 255));
		issue_command(send_item(random_word(), 4, 0));
		issue_command(send_item(random_word(), 4, 255));
		issue_command(send_item(random_word(), 1, 9));
		issue_command(send_item(random_word(), 5, 9));
		drain_queue();
		set_limits(0, 0);
		issue_command(send_item(random_word(), 1, 9));
		issue_command(receive_item(8));
		issue_command(receive_item(15));
		issue_command(receive_item(3));
		issue_command(receive_item(8));

		// random phases over several register settings and idle rates
		for (int p = 0; p < 9; p++) begin
			drain_queue();
			set_limits(caps[p], sizes[p]);
			filling = 1'b1;
			for (int k = 0; k < 180; k++) begin
				if ($urandom_range(15) == 0) begin
					filling = !filling;
				end
				while ($urandom_range(99) < idles[p]) begin
					start <= 1'b0;
					@(posedge clk);
				end
				issue_command(random_item(filling));
			end
		end

		drain_queue();
		repeat (3) @(posedge clk);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
